### hw/rtl/fmpd_pkg.sv
// ----------------------------------------------------------------------------
// fmpd_pkg
// Shared sizes, constants and the CORDIC arctangent table for the FM phase
// discriminator with boxcar decimation.
// ----------------------------------------------------------------------------
`default_nettype none

package fmpd_pkg;

  // Sample and phase widths.
  localparam int SAMPLE_W     = 8;
  localparam int PHASE_W      = 16;
  localparam int ANGLE_W      = 32;

  // CORDIC datapath: samples are scaled by 2^16 and grow by the CORDIC gain.
  localparam int SCALE_SHIFT  = 16;
  localparam int XY_W         = 27;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;

  // Accumulator and decimation.
  localparam int SUM_W        = 22;
  localparam int DEC_W        = 7;
  localparam int DEC_MAX      = 64;
  localparam logic [DEC_W-1:0] DEC_RESET = 7'd40;

  // Depth of the small queues between the stages.
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // Quarter-turn angle offsets for the pre-rotation into the right half plane.
  localparam logic [ANGLE_W-1:0] ANGLE_PLUS_90  = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_MINUS_90 = 32'hC000_0000;

  // atan(2^-k) in units of 2^32 per full circle.
  function automatic logic [ANGLE_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] k);
    logic [ANGLE_W-1:0] v;
    case (k)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fmpd_fifo.sv
// ----------------------------------------------------------------------------
// fmpd_fifo
// Small first-in first-out queue of phase-width words, used between the
// CORDIC and the accumulator and again in front of the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpd_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [fmpd_pkg::PHASE_W-1:0] wr_data,
  output logic                             full,
  input  wire logic                        rd_en,
  output logic [fmpd_pkg::PHASE_W-1:0]     rd_data,
  output logic                             empty
);
  import fmpd_pkg::*;

  logic [PHASE_W-1:0]    entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  // A beat moves only when the queue can take or give it.
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("fifo fill count above depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("fifo fill count did not grow on a lone write");

endmodule

`default_nettype wire

### hw/rtl/fmpd_front.sv
// ----------------------------------------------------------------------------
// fmpd_front
// Accepts I/Q beats and finds their phase with an iterative vectoring CORDIC,
// one micro-rotation per cycle, then hands the phase to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpd_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [fmpd_pkg::SAMPLE_W-1:0] i_sample,
  input  wire logic [fmpd_pkg::SAMPLE_W-1:0] q_sample,
  output logic                              phase_wr,
  output logic [fmpd_pkg::PHASE_W-1:0]      phase_data,
  input  wire logic                         phase_full
);
  import fmpd_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RUN  = 3'b010,
    F_DONE = 3'b100
  } front_state_t;

  localparam logic [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) << (ANGLE_W - PHASE_W - 1);
  localparam int EXT_W = XY_W - SAMPLE_W - SCALE_SHIFT;

  front_state_t              state;
  logic signed [XY_W-1:0]    x;
  logic signed [XY_W-1:0]    y;
  logic [ANGLE_W-1:0]        ang;
  logic [STEP_W-1:0]         step;
  logic [PHASE_W-1:0]        phase;

  logic signed [XY_W-1:0]    x_in;
  logic signed [XY_W-1:0]    y_in;
  logic signed [XY_W-1:0]    dx;
  logic signed [XY_W-1:0]    dy;
  logic [ANGLE_W-1:0]        ang_step;
  logic [ANGLE_W-1:0]        ang_round;
  logic                      last_step;

  assign full       = (state != F_IDLE);
  assign phase_wr   = (state == F_DONE) && !phase_full;
  assign phase_data = phase;

  // Incoming samples scaled by 2^16.
  assign x_in = {{EXT_W{i_sample[SAMPLE_W-1]}}, i_sample, SCALE_SHIFT'(0)};
  assign y_in = {{EXT_W{q_sample[SAMPLE_W-1]}}, q_sample, SCALE_SHIFT'(0)};

  // One micro-rotation: floor shifts and a table angle.
  assign dx        = y >>> step;
  assign dy        = x >>> step;
  assign ang_step  = y[XY_W-1] ? (ang - atan_entry(ATAN_IDX_W'(step)))
                               : (ang + atan_entry(ATAN_IDX_W'(step)));
  assign ang_round = ang_step + ROUND_HALF;
  assign last_step = (step == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            step <= '0;
            if (i_sample == '0 && q_sample == '0) begin
              // The zero vector has phase zero.
              phase <= '0;
              state <= F_DONE;
            end else begin
              if (i_sample[SAMPLE_W-1]) begin
                // Rotate the left half plane by a quarter turn.
                if (!q_sample[SAMPLE_W-1]) begin
                  x   <= y_in;
                  y   <= -x_in;
                  ang <= ANGLE_PLUS_90;
                end else begin
                  x   <= -y_in;
                  y   <= x_in;
                  ang <= ANGLE_MINUS_90;
                end
              end else begin
                x   <= x_in;
                y   <= y_in;
                ang <= '0;
              end
              state <= F_RUN;
            end
          end
        end
        F_RUN: begin
          if (y[XY_W-1]) begin
            x <= x - dx;
            y <= y + dy;
          end else begin
            x <= x + dx;
            y <= y - dy;
          end
          ang <= ang_step;
          if (last_step) begin
            phase <= ang_round[ANGLE_W-1 -: PHASE_W];
            state <= F_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        F_DONE: begin
          if (!phase_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == F_RUN && last_step) |=> (state == F_DONE))
    else $error("CORDIC did not finish after its last step");

endmodule

`default_nettype wire

### hw/rtl/fmpd_back.sv
// ----------------------------------------------------------------------------
// fmpd_back
// Takes phases from the queue, forms the wrapped phase difference, sums it,
// and at the end of each block divides the sum by the decimation factor with
// a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [fmpd_pkg::DEC_W-1:0]    decimation_factor,
  input  wire logic                          phase_empty,
  input  wire logic [fmpd_pkg::PHASE_W-1:0]  phase_data,
  output logic                               phase_rd,
  output logic                               out_wr,
  output logic [fmpd_pkg::PHASE_W-1:0]       out_data,
  input  wire logic                          out_full
);
  import fmpd_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } back_state_t;

  localparam int REM_W     = DEC_W + 1;
  localparam int DSTEP_W   = $clog2(SUM_W);

  back_state_t               state;
  logic [PHASE_W-1:0]        prev_phase;
  logic signed [SUM_W-1:0]   sum;
  logic [DEC_W-1:0]          count;
  logic [SUM_W-1:0]          quo;
  logic [REM_W-1:0]          rem;
  logic [DEC_W-1:0]          den;
  logic                      neg;
  logic [DSTEP_W-1:0]        dstep;
  logic [PHASE_W-1:0]        audio;

  logic [PHASE_W-1:0]        diff;
  logic signed [SUM_W-1:0]   sum_next;
  logic [DEC_W-1:0]          count_next;
  logic [DEC_W-1:0]          dec_eff;
  logic                      block_end;
  logic [SUM_W-1:0]          sum_mag;
  logic [REM_W-1:0]          rem_shift;
  logic                      qbit;
  logic [SUM_W-1:0]          quo_next;

  assign phase_rd = (state == B_IDLE) && !phase_empty;
  assign out_wr   = (state == B_OUT) && !out_full;
  assign out_data = audio;

  // Factor zero acts as one; factors above the maximum act as the maximum.
  always_comb begin
    if (decimation_factor == '0) begin
      dec_eff = DEC_W'(1);
    end else if (decimation_factor > DEC_W'(DEC_MAX)) begin
      dec_eff = DEC_W'(DEC_MAX);
    end else begin
      dec_eff = decimation_factor;
    end
  end

  // Wrapped difference, running sum and block count.
  assign diff       = phase_data - prev_phase;
  assign sum_next   = sum + {{(SUM_W-PHASE_W){diff[PHASE_W-1]}}, diff};
  assign count_next = count + 1'b1;
  assign block_end  = (count_next >= dec_eff);
  assign sum_mag    = sum_next[SUM_W-1] ? (~sum_next + 1'b1) : sum_next;

  // One restoring division step.
  assign rem_shift = {rem[REM_W-2:0], quo[SUM_W-1]};
  assign qbit      = (rem_shift >= {1'b0, den});
  assign quo_next  = {quo[SUM_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      prev_phase <= '0;
      sum        <= '0;
      count      <= '0;
      dstep      <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!phase_empty) begin
            prev_phase <= phase_data;
            if (block_end) begin
              // Start the division of the finished block sum.
              neg   <= sum_next[SUM_W-1];
              quo   <= sum_mag;
              rem   <= '0;
              den   <= dec_eff;
              dstep <= '0;
              sum   <= '0;
              count <= '0;
              state <= B_DIV;
            end else begin
              sum   <= sum_next;
              count <= count_next;
            end
          end
        end
        B_DIV: begin
          rem <= qbit ? (rem_shift - {1'b0, den}) : rem_shift;
          quo <= quo_next;
          if (dstep == DSTEP_W'(SUM_W - 1)) begin
            // Truncation toward zero: divide the magnitude, then restore sign.
            audio <= neg ? (~quo_next[PHASE_W-1:0] + 1'b1) : quo_next[PHASE_W-1:0];
            state <= B_OUT;
          end else begin
            dstep <= dstep + 1'b1;
          end
        end
        B_OUT: begin
          if (!out_full) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count < DEC_W'(DEC_MAX))
    else $error("block count reached the maximum factor without a result");

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (phase_rd && block_end) |=> (state == B_DIV && count == '0 && sum == '0))
    else $error("sum and count not cleared at the end of a block");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (dstep < DSTEP_W'(SUM_W)))
    else $error("divider ran past its last step");

endmodule

`default_nettype wire

### hw/rtl/fm_phase_discriminator_decimator.sv
// ----------------------------------------------------------------------------
// fm_phase_discriminator_decimator
// FM phase discriminator with boxcar decimation.
//
// Input channel: write an I/Q pair with push while full is low. The front
// end takes one pair and then runs a 16-step iterative CORDIC; full stays
// high until its phase is written to the phase queue, and no new pair is
// taken meanwhile. A zero pair skips the CORDIC.
// A two-entry phase queue decouples the front end from the back end, which
// takes one phase per cycle while idle and the queue holds one, sums the
// wrapped differences and, at the end of each block of decimation_factor
// pairs, runs a bit-serial divide of its 22-bit sum. A block end holds the
// back end while it divides and writes the result, so with a factor of one
// each pair waits for a divide before the next phase is taken.
// Result channel: audio_sample is valid while empty is low and is taken with
// pop. A two-entry result queue holds finished beats; when the receiver
// stalls, the queues fill and full then stays high until pop frees space.
// Configuration: cfg_wr_en writes decimation_factor at once. The user must
// write it only when idle; the block itself does not enforce this.
// Reset (rst, synchronous): factor 40, phase, sum, count and queues cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_phase_discriminator_decimator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [fmpd_pkg::SAMPLE_W-1:0] i_sample,
  input  wire logic signed [fmpd_pkg::SAMPLE_W-1:0] q_sample,
  input  wire logic                          pop,
  output logic                               empty,
  output logic signed [fmpd_pkg::PHASE_W-1:0] audio_sample,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fmpd_pkg::DEC_W-1:0]    cfg_wr_data
);
  import fmpd_pkg::*;

  logic [DEC_W-1:0]   decimation_factor;
  logic               phase_wr;
  logic [PHASE_W-1:0] phase_wdata;
  logic               phase_full;
  logic               phase_rd;
  logic [PHASE_W-1:0] phase_rdata;
  logic               phase_empty;
  logic               out_wr;
  logic [PHASE_W-1:0] out_wdata;
  logic               out_full;
  logic [PHASE_W-1:0] out_rdata;

  // Decimation factor register.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_factor <= DEC_RESET;
    end else if (cfg_wr_en) begin
      decimation_factor <= cfg_wr_data;
    end
  end

  // Front end: CORDIC phase.
  fmpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .i_sample   (i_sample),
    .q_sample   (q_sample),
    .phase_wr   (phase_wr),
    .phase_data (phase_wdata),
    .phase_full (phase_full)
  );

  // Queue of phases between the two ends.
  fmpd_fifo u_phase_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (phase_wr),
    .wr_data (phase_wdata),
    .full    (phase_full),
    .rd_en   (phase_rd),
    .rd_data (phase_rdata),
    .empty   (phase_empty)
  );

  // Back end: difference, sum and divide.
  fmpd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .decimation_factor (decimation_factor),
    .phase_empty       (phase_empty),
    .phase_data        (phase_rdata),
    .phase_rd          (phase_rd),
    .out_wr            (out_wr),
    .out_data          (out_wdata),
    .out_full          (out_full)
  );

  // Result queue facing the receiver.
  fmpd_fifo u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_wdata),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_rdata),
    .empty   (empty)
  );

  assign audio_sample = out_rdata;

endmodule

`default_nettype wire
